>>> rtl/tcspq_pkg.sv
package tcspq_pkg;

  localparam int ID_W  = 32;
  localparam int AGE_W = 8;
  localparam int CLS_W = 2;
  localparam int ST_W  = 3;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [ST_W-1:0] ST_ENQUEUED = 3'd0;
  localparam logic [ST_W-1:0] ST_SERVED   = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [ST_W-1:0] ST_BADCLASS = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic             op;
    logic [ID_W-1:0]  patient_id;
    logic [AGE_W-1:0] patient_age;
    logic [CLS_W-1:0] priority_class;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [ID_W-1:0]  served_id;
    logic [AGE_W-1:0] served_age;
    logic [CLS_W-1:0] served_class;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [AGE_W-1:0] age;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic commit;
    logic load_read;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic served;
  } stat_t;

endpackage

>>> rtl/tcspq_ctrl.sv
module tcspq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tcspq_pkg::stat_t stat,
  output tcspq_pkg::cmd_t  cmd
);
  import tcspq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_READ = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.capture   = 1'b0;
    cmd.commit    = 1'b0;
    cmd.load_read = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = stat.served ? S_READ : S_IDLE;
        end
      end
      S_READ: begin
        cmd.load_read = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_read_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> $past(state_r == S_EXEC))
    else $error("read state not entered from exec");

  a_commit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> stat.out_free)
    else $error("commit while output register occupied");

endmodule

>>> rtl/tcspq_dp.sv
module tcspq_dp #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_CLASSES = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcspq_pkg::in_item_t  in_data,
  input  tcspq_pkg::cmd_t      cmd,
  output tcspq_pkg::stat_t     stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tcspq_pkg::out_item_t out_data
);
  import tcspq_pkg::*;

  localparam int DEPTH = NUM_CLASSES * QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int FW    = $clog2(QUEUE_DEPTH + 1);
  localparam int CW    = $clog2(NUM_CLASSES);

  in_item_t  item_r;
  logic [PW-1:0] head_r [NUM_CLASSES];
  logic [PW-1:0] tail_r [NUM_CLASSES];
  logic [FW-1:0] cnt_r  [NUM_CLASSES];
  entry_t    mem_r [DEPTH];
  entry_t    rd_data_r;
  logic [CW-1:0] srv_cls_r;
  logic      out_valid_r;
  out_item_t out_data_r;

  logic          enq, bad, full, any, do_wr, do_rd;
  logic [CW-1:0] ecls, pick;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [ST_W-1:0] res_status;

  function automatic logic [PW-1:0] nxt_ptr(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    enq  = (item_r.op == OP_ENQ);
    bad  = 32'(item_r.priority_class) >= 32'(NUM_CLASSES);
    ecls = CW'(item_r.priority_class);
    full = bad ? 1'b0 : (cnt_r[ecls] == FW'(QUEUE_DEPTH));
    any  = 1'b0;
    pick = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (cnt_r[c] != '0) begin
        any  = 1'b1;
        pick = CW'(c);
      end
    end
    wr_addr = AW'(int'(ecls) * QUEUE_DEPTH) + AW'(tail_r[ecls]);
    rd_addr = AW'(int'(pick) * QUEUE_DEPTH) + AW'(head_r[pick]);
    do_wr   = cmd.commit && enq && !bad && !full;
    do_rd   = cmd.commit && !enq && any;
    if (!enq) begin
      res_status = ST_EMPTY;
    end else if (bad) begin
      res_status = ST_BADCLASS;
    end else if (full) begin
      res_status = ST_FULL;
    end else begin
      res_status = ST_ENQUEUED;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign stat.served   = !enq && any;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_r[c] <= '0;
        tail_r[c] <= '0;
        cnt_r[c]  <= '0;
      end
    end else if (do_wr) begin
      tail_r[ecls] <= nxt_ptr(tail_r[ecls]);
      cnt_r[ecls]  <= cnt_r[ecls] + 1'b1;
    end else if (do_rd) begin
      head_r[pick] <= nxt_ptr(head_r[pick]);
      cnt_r[pick]  <= cnt_r[pick] - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_addr] <= '{id: item_r.patient_id, age: item_r.patient_age};
    end
    if (do_rd) begin
      rd_data_r <= mem_r[rd_addr];
      srv_cls_r <= pick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.commit && !stat.served) || cmd.load_read) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !stat.served) begin
      out_data_r <= '{status: res_status, served_id: '0, served_age: '0, served_class: '0};
    end else if (cmd.load_read) begin
      out_data_r <= '{status: ST_SERVED, served_id: rd_data_r.id,
                      served_age: rd_data_r.age, served_class: CLS_W'(srv_cls_r)};
    end
  end

  a_read_follows_serve: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && stat.served |=> cmd.load_read)
    else $error("read data not loaded after served dequeue");

  a_load_into_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_read |-> !out_valid_r)
    else $error("read data loaded over pending item");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[pick] <= FW'(QUEUE_DEPTH) && (!do_wr || cnt_r[ecls] < FW'(QUEUE_DEPTH)))
    else $error("fill count above queue depth");

endmodule

>>> rtl/three_class_strict_priority_queue.sv
// Channel  Ports                           Accepted when
// input    in_valid, in_ready, in_data     in_valid && in_ready
// result   out_valid, out_ready, out_data  out_valid && out_ready
//
// One item at a time: an enqueue or empty dequeue goes through idle and exec, a
// served dequeue also through read (loading the registered entry memory read).
// The next item is taken while the previous result waits in the output register.
// A new result waits in the exec state until the output register is free.
// Reset (rst_n low, synchronous) empties all class queues; memory is not cleared.
module three_class_strict_priority_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_CLASSES = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tcspq_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tcspq_pkg::out_item_t out_data
);
  import tcspq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tcspq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcspq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import tcspq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int CLASSES      = 3;
  localparam int RANDOM_ITEMS = 1950;

  logic      clk;
  logic      rst_n    = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data  = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  three_class_strict_priority_queue #(
    .QUEUE_DEPTH(DEPTH),
    .NUM_CLASSES(CLASSES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  typedef struct {
    in_item_t    item;
    int unsigned reps;
    bit          typed;
    out_item_t   want;
  } plan_row_t;

  entry_t      ward [CLASSES][$];
  out_item_t   owed_outcomes [$];
  plan_row_t   plan [$];
  int          mismatches = 0;
  int          burst_left = 0;

  logic [15:0] stall_pat = 16'h1;
  int          stall_mode = 0;
  int          stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic out_item_t triage(input in_item_t it);
    out_item_t r;
    entry_t    e;
    bit        found;
    r = '0;
    found = 1'b0;
    if (it.op == OP_ENQ) begin
      if (it.priority_class >= CLASSES) begin
        r.status = ST_BADCLASS;
      end else if (ward[it.priority_class].size() >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        e.id  = it.patient_id;
        e.age = it.patient_age;
        ward[it.priority_class].push_back(e);
        r.status = ST_ENQUEUED;
      end
    end else begin
      r.status = ST_EMPTY;
      for (int c = 0; c < CLASSES; c++) begin
        if (!found && ward[c].size() != 0) begin
          found          = 1'b1;
          e              = ward[c].pop_front();
          r.status       = ST_SERVED;
          r.served_id    = e.id;
          r.served_age   = e.age;
          r.served_class = c[CLS_W-1:0];
        end
      end
    end
    return r;
  endfunction

  task automatic add_row(input logic op, input logic [ID_W-1:0] id,
                         input logic [AGE_W-1:0] age, input logic [CLS_W-1:0] cls,
                         input int unsigned reps, input bit typed,
                         input logic [ST_W-1:0] st);
    plan_row_t row;
    row.item.op             = op;
    row.item.patient_id     = id;
    row.item.patient_age    = age;
    row.item.priority_class = cls;
    row.reps                = reps;
    row.typed               = typed;
    row.want                = '0;
    row.want.status         = st;
    plan.push_back(row);
  endtask

  task automatic offer(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t got;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    got = triage(it);
    owed_outcomes.push_back(typed ? want : got);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 60);
    end else begin
      burst_left--;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (owed_outcomes.size() == 0) begin
        $display("%0t: unexpected item status=%0d id=%h age=%h class=%0d", $time,
                 out_data.status, out_data.served_id, out_data.served_age,
                 out_data.served_class);
        mismatches++;
      end else begin
        if (out_data !== owed_outcomes[0]) begin
          $display("%0t: mismatch expected status=%0d id=%h age=%h class=%0d", $time,
                   owed_outcomes[0].status, owed_outcomes[0].served_id,
                   owed_outcomes[0].served_age, owed_outcomes[0].served_class);
          $display("%0t:          actual   status=%0d id=%h age=%h class=%0d", $time,
                   out_data.status, out_data.served_id, out_data.served_age,
                   out_data.served_class);
          mismatches++;
        end
        void'(owed_outcomes.pop_front());
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(30, 300);
      stall_pat  = 16'($urandom) | 16'h1;
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[15:1]};
      end
      default: begin
        out_ready <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  initial begin
    in_item_t it;
    int       done;
    int       phase_len;
    int       enq_pct;

    // empty, ignored dequeue fields, bad class, fill class 2 to full, extremes
    add_row(OP_DEQ, 32'h0000_0000, 8'h00, 2'd0, 1, 1'b1, ST_EMPTY);
    add_row(OP_DEQ, 32'hFFFF_FFFF, 8'hFF, 2'd3, 1, 1'b1, ST_EMPTY);
    add_row(OP_ENQ, 32'hDEAD_BEEF, 8'h7F, 2'd3, 1, 1'b1, ST_BADCLASS);
    add_row(OP_ENQ, 32'h1000_0000, 8'h40, 2'd2, DEPTH, 1'b0, ST_ENQUEUED);
    add_row(OP_ENQ, 32'hFFFF_0000, 8'h01, 2'd2, 1, 1'b1, ST_FULL);
    add_row(OP_ENQ, 32'h0000_0000, 8'h00, 2'd0, 1, 1'b1, ST_ENQUEUED);
    add_row(OP_ENQ, 32'hFFFF_FFFF, 8'hFF, 2'd1, 1, 1'b1, ST_ENQUEUED);
    add_row(OP_DEQ, 32'hFFFF_FFFF, 8'hFF, 2'd3, 1, 1'b0, ST_SERVED);
    add_row(OP_DEQ, 32'h0000_0000, 8'h00, 2'd0, 1, 1'b0, ST_SERVED);
    add_row(OP_DEQ, 32'h5555_AAAA, 8'hA5, 2'd1, 1, 1'b0, ST_SERVED);
    add_row(OP_ENQ, 32'h8000_0001, 8'h80, 2'd2, 1, 1'b0, ST_ENQUEUED);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[r]) begin
      for (int unsigned k = 0; k < plan[r].reps; k++) begin
        it = plan[r].item;
        it.patient_id = it.patient_id + k;
        offer(it, plan[r].typed, plan[r].want);
      end
    end

    // phases biased toward filling or draining (or balanced) so full and wrap come up often
    done = 0;
    while (done < RANDOM_ITEMS) begin
      phase_len = $urandom_range(20, 120);
      case ($urandom_range(0, 2))
        0:       enq_pct = 85;
        1:       enq_pct = 50;
        default: enq_pct = 15;
      endcase
      for (int k = 0; k < phase_len && done < RANDOM_ITEMS; k++) begin
        it.patient_id  = $urandom;
        it.patient_age = AGE_W'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < enq_pct) begin
          it.op = OP_ENQ;
          if ($urandom_range(0, 24) == 0) begin
            it.priority_class = 2'd3;
          end else begin
            it.priority_class = CLS_W'($urandom_range(0, CLASSES - 1));
          end
        end else begin
          it.op             = OP_DEQ;
          it.priority_class = CLS_W'($urandom_range(0, 3));
        end
        offer(it, 1'b0, '0);
        done++;
      end
    end

    in_valid <= 1'b0;
    while (owed_outcomes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
